>>> rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the RGBA bilinear scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int SCOORD_W    = 8;
   localparam int DCOORD_W    = 12;
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 4 * CHAN_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_WRITE   = 1'b0,
      ACT_REQUEST = 1'b1
   } action_type;

   // neighbor select: bit 0 right column, bit 1 lower row
   typedef enum logic [1:0] {
      NB_00 = 2'b00,
      NB_01 = 2'b01,
      NB_10 = 2'b10,
      NB_11 = 2'b11
   } nb_type;

   typedef struct packed {
      logic   load_req;
      logic   wr_px;
      logic   mul;
      logic   cdiv_start;
      nb_type rd_sel;
      logic   cap_en;
      nb_type cap_sel;
      logic   wgt;
      logic   prod;
      logic   ldiv_start;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic cdiv_busy;
      logic ldiv_busy;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/rbs_req_if.sv
// ----------------------------------------------------------------------------
// rbs_req_if
// Request channel: pixel writes and destination pixel requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbs_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  src_col;
   logic [7:0]  src_row;
   logic [7:0]  red_in;
   logic [7:0]  green_in;
   logic [7:0]  blue_in;
   logic [7:0]  alpha_in;
   logic [11:0] dst_col;
   logic [11:0] dst_row;

   modport source (output valid, action, src_col, src_row, red_in, green_in, blue_in,
                   alpha_in, dst_col, dst_row, input ready);
   modport sink (input valid, action, src_col, src_row, red_in, green_in, blue_in,
                 alpha_in, dst_col, dst_row, output ready);
endinterface

`default_nettype wire

>>> rtl/rbs_rsp_if.sv
// ----------------------------------------------------------------------------
// rbs_rsp_if
// Response channel: interpolated destination pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       out_of_range;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, out_of_range,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, out_of_range,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/rbs_ram.sv
// ----------------------------------------------------------------------------
// rbs_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/rbs_div.sv
// ----------------------------------------------------------------------------
// rbs_div
// Restoring divider, one quotient bit per cycle, for quotients of QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_div #(
   parameter int NW  = 21,
   parameter int QW  = 8,
   parameter int DVW = 13
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [NW-1:0]  dividend,
   input  wire logic [DVW-1:0] divisor,
   output logic                busy,
   output logic      [QW-1:0]  quotient,
   output logic      [DVW-1:0] remainder
);

   localparam int CW = $clog2(QW + 1);

   logic           busy_ff, busy_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [QW-1:0]  low_ff, low_in;
   logic [DVW-1:0] div_ff, div_in;
   logic [DVW:0]   trial;
   logic [DVW:0]   diff;
   logic           ge;

   always_comb begin
      trial   = {rem_ff, low_ff[QW-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         rem_in  = DVW'(dividend >> QW);
         low_in  = dividend[QW-1:0];
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVW-1:0] : trial[DVW-1:0];
         low_in = QW'({low_ff, ge});
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = low_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/rbs_datapath.sv
// ----------------------------------------------------------------------------
// rbs_datapath
// Size registers, source image memory, coordinate and channel arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_datapath #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_SIZE   = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rbs_pkg::cmd_type                 cmd,
   output rbs_pkg::status_type                   status,
   input  wire logic                             csr_wr_en,
   input  wire logic [rbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rbs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [rbs_pkg::SCOORD_W-1:0]     src_col,
   input  wire logic [rbs_pkg::SCOORD_W-1:0]     src_row,
   input  wire logic [rbs_pkg::CHAN_W-1:0]       red_in,
   input  wire logic [rbs_pkg::CHAN_W-1:0]       green_in,
   input  wire logic [rbs_pkg::CHAN_W-1:0]       blue_in,
   input  wire logic [rbs_pkg::CHAN_W-1:0]       alpha_in,
   input  wire logic [rbs_pkg::DCOORD_W-1:0]     dst_col,
   input  wire logic [rbs_pkg::DCOORD_W-1:0]     dst_row,
   output logic      [rbs_pkg::CHAN_W-1:0]       red_out,
   output logic      [rbs_pkg::CHAN_W-1:0]       green_out,
   output logic      [rbs_pkg::CHAN_W-1:0]       blue_out,
   output logic      [rbs_pkg::CHAN_W-1:0]       alpha_out,
   output logic                                  out_of_range
);

   import rbs_pkg::*;

   localparam int XW   = $clog2(MAX_SRC_WIDTH);
   localparam int YW   = $clog2(MAX_SRC_HEIGHT);
   localparam int SWW  = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SHW  = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int DW   = $clog2(MAX_DST_SIZE + 1);
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW   = $clog2(DEPTH);
   localparam int PXW  = DCOORD_W + SWW;
   localparam int PYW  = DCOORD_W + SHW;
   localparam int HW   = CHAN_W + DW;
   localparam int SMW  = CHAN_W + 2 * DW;
   localparam int LNW  = 2 * DW + 9;
   localparam int LDVW = 2 * DW + 1;
   localparam int SW_RST = (256 > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : 256;
   localparam int SH_RST = (256 > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : 256;
   localparam int DS_RST = (256 > MAX_DST_SIZE) ? MAX_DST_SIZE : 256;

   // size registers, held already clamped
   logic [SWW-1:0] sw_ff, sw_in;
   logic [SHW-1:0] sh_ff, sh_in;
   logic [DW-1:0]  dw_ff, dw_in;
   logic [DW-1:0]  dh_ff, dh_in;
   logic [8:0]     v9;
   logic [12:0]    v13;

   always_comb begin
      v9    = csr_wdata[8:0];
      v13   = csr_wdata[12:0];
      sw_in = sw_ff;
      sh_in = sh_ff;
      dw_in = dw_ff;
      dh_in = dh_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH: begin
               if (v9 == 9'd0) sw_in = SWW'(1);
               else if (32'(v9) > MAX_SRC_WIDTH) sw_in = SWW'(MAX_SRC_WIDTH);
               else sw_in = SWW'(v9);
            end
            CSR_SRC_HEIGHT: begin
               if (v9 == 9'd0) sh_in = SHW'(1);
               else if (32'(v9) > MAX_SRC_HEIGHT) sh_in = SHW'(MAX_SRC_HEIGHT);
               else sh_in = SHW'(v9);
            end
            CSR_DST_WIDTH: begin
               if (v13 == 13'd0) dw_in = DW'(1);
               else if (32'(v13) > MAX_DST_SIZE) dw_in = DW'(MAX_DST_SIZE);
               else dw_in = DW'(v13);
            end
            CSR_DST_HEIGHT: begin
               if (v13 == 13'd0) dh_in = DW'(1);
               else if (32'(v13) > MAX_DST_SIZE) dh_in = DW'(MAX_DST_SIZE);
               else dh_in = DW'(v13);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= SWW'(SW_RST);
         sh_ff <= SHW'(SH_RST);
         dw_ff <= DW'(DS_RST);
         dh_ff <= DW'(DS_RST);
      end else begin
         sw_ff <= sw_in;
         sh_ff <= sh_in;
         dw_ff <= dw_in;
         dh_ff <= dh_in;
      end
   end

   // request capture and first products
   logic [DCOORD_W-1:0] i_ff, j_ff;
   logic [PXW-1:0]      prod_x_ff;
   logic [PYW-1:0]      prod_y_ff;
   logic [2*DW-1:0]     denom_ff;
   logic                oor_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         i_ff <= dst_col;
         j_ff <= dst_row;
      end
      if (cmd.mul) begin
         prod_x_ff <= PXW'(i_ff) * PXW'(sw_ff);
         prod_y_ff <= PYW'(j_ff) * PYW'(sh_ff);
         denom_ff  <= (2*DW)'(dw_ff) * (2*DW)'(dh_ff);
         oor_ff    <= (32'(i_ff) >= 32'(dw_ff)) || (32'(j_ff) >= 32'(dh_ff));
      end
   end

   // coordinate division
   logic [XW-1:0] si;
   logic [YW-1:0] sj;
   logic [DW-1:0] fx, fy;
   logic          bx, by;

   rbs_div #(.NW(PXW), .QW(XW), .DVW(DW)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.cdiv_start),
      .dividend  (prod_x_ff),
      .divisor   (dw_ff),
      .busy      (bx),
      .quotient  (si),
      .remainder (fx)
   );

   rbs_div #(.NW(PYW), .QW(YW), .DVW(DW)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.cdiv_start),
      .dividend  (prod_y_ff),
      .divisor   (dh_ff),
      .busy      (by),
      .quotient  (sj),
      .remainder (fy)
   );

   // neighbor addresses, clamped at the right and bottom edges
   logic [XW-1:0]  si1, rcol;
   logic [YW-1:0]  sj1, rrow;
   logic [AW-1:0]  raddr, waddr;
   logic           wr_ok;
   logic [PIXEL_W-1:0] rdata;

   always_comb begin
      si1   = (32'(si) >= 32'(sw_ff) - 1) ? si : si + XW'(1);
      sj1   = (32'(sj) >= 32'(sh_ff) - 1) ? sj : sj + YW'(1);
      rcol  = cmd.rd_sel[0] ? si1 : si;
      rrow  = cmd.rd_sel[1] ? sj1 : sj;
      raddr = AW'(AW'(rrow) * AW'(MAX_SRC_WIDTH) + AW'(rcol));
      wr_ok = (32'(src_col) < MAX_SRC_WIDTH) && (32'(src_row) < MAX_SRC_HEIGHT);
      waddr = AW'(AW'(src_row) * AW'(MAX_SRC_WIDTH) + AW'(src_col));
   end

   rbs_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH)) u_image (
      .clock (clock),
      .we    (cmd.wr_px && wr_ok),
      .waddr (waddr),
      .wdata ({alpha_in, blue_in, green_in, red_in}),
      .raddr (raddr),
      .rdata (rdata)
   );

   logic [PIXEL_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         unique case (cmd.cap_sel)
            NB_00: p00_ff <= rdata;
            NB_01: p01_ff <= rdata;
            NB_10: p10_ff <= rdata;
            NB_11: p11_ff <= rdata;
            default: ;
         endcase
      end
   end

   // weights
   logic [DW-1:0] wx0, wy0;
   assign wx0 = dw_ff - fx;
   assign wy0 = dh_ff - fy;

   // per-channel lanes
   logic [3:0]        lane_busy;
   logic [CHAN_W-1:0] lane_q [4];

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [CHAN_W-1:0] c00, c01, c10, c11;
      logic [HW-1:0]     htop_ff, hbot_ff;
      logic [SMW-1:0]    s0_ff, s1_ff;
      logic [LNW-1:0]    num;

      assign c00 = p00_ff[CHAN_W*k +: CHAN_W];
      assign c01 = p01_ff[CHAN_W*k +: CHAN_W];
      assign c10 = p10_ff[CHAN_W*k +: CHAN_W];
      assign c11 = p11_ff[CHAN_W*k +: CHAN_W];
      assign num = LNW'({LNW'(s0_ff) + LNW'(s1_ff), 1'b0}) + LNW'(denom_ff);

      always_ff @(posedge clock) begin
         if (cmd.wgt) begin
            htop_ff <= HW'(c00) * HW'(wx0) + HW'(c01) * HW'(fx);
            hbot_ff <= HW'(c10) * HW'(wx0) + HW'(c11) * HW'(fx);
         end
         if (cmd.prod) begin
            s0_ff <= SMW'(htop_ff) * SMW'(wy0);
            s1_ff <= SMW'(hbot_ff) * SMW'(fy);
         end
      end

      rbs_div #(.NW(LNW), .QW(CHAN_W), .DVW(LDVW)) u_div_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (cmd.ldiv_start),
         .dividend  (num),
         .divisor   ({denom_ff, 1'b0}),
         .busy      (lane_busy[k]),
         .quotient  (lane_q[k]),
         .remainder ()
      );
   end

   // result register
   logic [CHAN_W-1:0] r_ff, g_ff, b_ff, a_ff;
   logic              oor_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         oor_out_ff <= oor_ff;
         r_ff <= oor_ff ? '0 : lane_q[0];
         g_ff <= oor_ff ? '0 : lane_q[1];
         b_ff <= oor_ff ? '0 : lane_q[2];
         a_ff <= oor_ff ? '0 : lane_q[3];
      end
   end

   assign red_out      = r_ff;
   assign green_out    = g_ff;
   assign blue_out     = b_ff;
   assign alpha_out    = a_ff;
   assign out_of_range = oor_out_ff;

   assign status.oor       = oor_ff;
   assign status.cdiv_busy = bx | by;
   assign status.ldiv_busy = |lane_busy;

endmodule

`default_nettype wire

>>> rtl/rbs_ctrl.sv
// ----------------------------------------------------------------------------
// rbs_ctrl
// Sequencer for pixel writes and destination pixel requests.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_action,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rbs_pkg::cmd_type         cmd,
   input  wire rbs_pkg::status_type status
);

   import rbs_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_MUL    = 14'b00000000000010,
      ST_CSTART = 14'b00000000000100,
      ST_CWAIT  = 14'b00000000001000,
      ST_RD0    = 14'b00000000010000,
      ST_RD1    = 14'b00000000100000,
      ST_RD2    = 14'b00000001000000,
      ST_RD3    = 14'b00000010000000,
      ST_RLAST  = 14'b00000100000000,
      ST_WGT    = 14'b00001000000000,
      ST_PROD   = 14'b00010000000000,
      ST_LSTART = 14'b00100000000000,
      ST_LWAIT  = 14'b01000000000000,
      ST_FIN    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (action_type'(req_action) == ACT_REQUEST) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_MUL;
               end else begin
                  cmd.wr_px = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CSTART;
         end
         ST_CSTART: begin
            if (status.oor) begin
               state_in = ST_FIN;
            end else begin
               cmd.cdiv_start = 1'b1;
               state_in       = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            if (!status.cdiv_busy) state_in = ST_RD0;
         end
         ST_RD0: begin
            cmd.rd_sel = NB_00;
            state_in   = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_sel  = NB_01;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = NB_00;
            state_in    = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_sel  = NB_10;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = NB_01;
            state_in    = ST_RD3;
         end
         ST_RD3: begin
            cmd.rd_sel  = NB_11;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = NB_10;
            state_in    = ST_RLAST;
         end
         ST_RLAST: begin
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = NB_11;
            state_in    = ST_WGT;
         end
         ST_WGT: begin
            cmd.wgt  = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_LSTART;
         end
         ST_LSTART: begin
            cmd.ldiv_start = 1'b1;
            state_in       = ST_LWAIT;
         end
         ST_LWAIT: begin
            if (!status.ldiv_busy) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/rgba_bilinear_scaler_unit.sv
// ----------------------------------------------------------------------------
// rgba_bilinear_scaler_unit
// Bilinear scaler of a stored RGBA8888 source image.
//
// req_chan carries beats of two kinds: a pixel write (action 0) stores one
// source pixel without leaving idle and gives no response; a pixel request (action 1)
// gives one rsp_chan beat with the four interpolated channels, or zeros and
// out_of_range when the coordinates lie outside the destination image.
// csr_* writes the source and destination sizes, clamped to their legal range.
// A request's result is loaded into the response register in its last state,
// and the next beat is taken in the cycle after. On the way the request forms
// the coordinate products, runs an iterative coordinate division, makes four
// reads from the single image port, two multiply steps and an 8-step rounding
// division per channel. An out-of-range request skips straight to the response.
// One request is in flight at a time; req_chan.ready is high between them.
// The result sits in an output register, so the next beat is accepted while
// it waits; a further result holds until rsp_chan.ready frees the register.
// Reset restores 256x256 sizes and empties the response register; the image
// memory is not cleared and a pixel must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_bilinear_scaler_unit #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_DST_SIZE   = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rbs_req_if.sink                              req_chan,
   rbs_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [rbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   rbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   rbs_datapath #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .MAX_DST_SIZE   (MAX_DST_SIZE)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .src_col      (req_chan.src_col),
      .src_row      (req_chan.src_row),
      .red_in       (req_chan.red_in),
      .green_in     (req_chan.green_in),
      .blue_in      (req_chan.blue_in),
      .alpha_in     (req_chan.alpha_in),
      .dst_col      (req_chan.dst_col),
      .dst_row      (req_chan.dst_row),
      .red_out      (rsp_chan.red_out),
      .green_out    (rsp_chan.green_out),
      .blue_out     (rsp_chan.blue_out),
      .alpha_out    (rsp_chan.alpha_out),
      .out_of_range (rsp_chan.out_of_range)
   );

endmodule

`default_nettype wire

>>> tb/sv/rgba_bilinear_scaler_unit_tb.sv
// ----------------------------------------------------------------------------
// rgba_bilinear_scaler_unit_tb
// Self-checking bench for the RGBA bilinear scaler. A short table of
// directed beats runs at the reset sizes. It is followed by random phases
// over several source and destination sizes, extremes and clamped values
// among them. Each request is scored against its table value, if typed, or an
// integer bilinear predictor that keeps its own copy of the image. Every source
// pixel that a request touches is written before the request goes out.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_bilinear_scaler_unit_tb;
   import rbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SRC_MAX   = 256;
   localparam int DST_MAX   = 4096;
   localparam int IDLE_PCT  = 17;
   localparam int STALL_MAX = 4000;
   localparam int PHASE_LEN = 240;

   typedef struct packed {
      action_type  act;
      logic [7:0]  scol;
      logic [7:0]  srow;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] dcol;
      logic [11:0] drow;
   } pixel_beat_t;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       oor;
   } scaled_px_t;

   typedef struct packed {
      pixel_beat_t beat;
      logic        typed;
      scaled_px_t  want;
   } table_row_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rbs_req_if req_bus ();
   rbs_rsp_if rsp_bus ();

   rgba_bilinear_scaler_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [31:0] image_mem [SRC_MAX*SRC_MAX];
   bit          written_map [SRC_MAX*SRC_MAX];
   longint unsigned reg_sw, reg_sh, reg_dw, reg_dh;
   scaled_px_t  pending_px [$];
   bit          calm;
   int          errors, n_writes, n_reqs, n_oor, n_rsp, n_phases;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned eff(longint unsigned v, longint unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // source neighbors and remainders of a destination pixel
   function automatic void locate(input longint unsigned dc, input longint unsigned dr,
                                  output longint unsigned si, output longint unsigned si1,
                                  output longint unsigned sj, output longint unsigned sj1,
                                  output longint unsigned fx, output longint unsigned fy);
      longint unsigned sw, sh, dw, dh;
      sw = eff(reg_sw, SRC_MAX);
      sh = eff(reg_sh, SRC_MAX);
      dw = eff(reg_dw, DST_MAX);
      dh = eff(reg_dh, DST_MAX);
      si = (dc * sw) / dw;
      fx = (dc * sw) % dw;
      sj = (dr * sh) / dh;
      fy = (dr * sh) % dh;
      si1 = (si >= sw - 1) ? si : si + 1;
      sj1 = (sj >= sh - 1) ? sj : sj + 1;
   endfunction

   function automatic bit in_dst(longint unsigned dc, longint unsigned dr);
      return dc < eff(reg_dw, DST_MAX) && dr < eff(reg_dh, DST_MAX);
   endfunction

   function automatic scaled_px_t interpolate(longint unsigned dc, longint unsigned dr);
      scaled_px_t r;
      longint unsigned si, si1, sj, sj1, fx, fy, dw, dh, den, sum, v;
      logic [31:0] p00, p01, p10, p11;
      logic [7:0] chan [4];
      r = '0;
      if (!in_dst(dc, dr)) begin
         r.oor = 1'b1;
         return r;
      end
      dw = eff(reg_dw, DST_MAX);
      dh = eff(reg_dh, DST_MAX);
      locate(dc, dr, si, si1, sj, sj1, fx, fy);
      p00 = image_mem[sj * SRC_MAX + si];
      p01 = image_mem[sj * SRC_MAX + si1];
      p10 = image_mem[sj1 * SRC_MAX + si];
      p11 = image_mem[sj1 * SRC_MAX + si1];
      den = dw * dh;
      for (int ch = 0; ch < 4; ch++) begin
         sum = longint'(p00[8*ch +: 8]) * (dw - fx) * (dh - fy)
             + longint'(p01[8*ch +: 8]) * fx * (dh - fy)
             + longint'(p10[8*ch +: 8]) * (dw - fx) * fy
             + longint'(p11[8*ch +: 8]) * fx * fy;
         v = (2 * sum + den) / (2 * den);
         chan[ch] = (v > 255) ? 8'hFF : v[7:0];
      end
      r.red   = chan[0];
      r.green = chan[1];
      r.blue  = chan[2];
      r.alpha = chan[3];
      return r;
   endfunction

   task automatic push(input pixel_beat_t b, input bit typed, input scaled_px_t want);
      bit ok;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= b.act;
      req_bus.src_col  <= b.scol;
      req_bus.src_row  <= b.srow;
      req_bus.red_in   <= b.red;
      req_bus.green_in <= b.green;
      req_bus.blue_in  <= b.blue;
      req_bus.alpha_in <= b.alpha;
      req_bus.dst_col  <= b.dcol;
      req_bus.dst_row  <= b.drow;
      do begin
         @(negedge clock);
         ok = req_bus.ready;
         @(posedge clock);
      end while (!ok);
      if (b.act == ACT_WRITE) begin
         image_mem[b.srow * SRC_MAX + b.scol] = {b.alpha, b.blue, b.green, b.red};
         written_map[b.srow * SRC_MAX + b.scol] = 1'b1;
         n_writes++;
      end else begin
         pending_px.push_back(typed ? want : interpolate(b.dcol, b.drow));
         n_reqs++;
         if (!in_dst(b.dcol, b.drow)) n_oor++;
      end
   endtask

   task automatic write_px(input longint unsigned col, input longint unsigned row);
      pixel_beat_t b;
      b = '0;
      b.act   = ACT_WRITE;
      b.scol  = col[7:0];
      b.srow  = row[7:0];
      b.red   = 8'($urandom);
      b.green = 8'($urandom);
      b.blue  = 8'($urandom);
      b.alpha = 8'($urandom);
      push(b, 1'b0, '0);
   endtask

   // fill any unwritten neighbor first, then request
   task automatic request_px(input logic [11:0] dc, input logic [11:0] dr);
      pixel_beat_t b;
      longint unsigned si, si1, sj, sj1, fx, fy;
      if (in_dst(dc, dr)) begin
         locate(dc, dr, si, si1, sj, sj1, fx, fy);
         if (!written_map[sj * SRC_MAX + si]) write_px(si, sj);
         if (!written_map[sj * SRC_MAX + si1]) write_px(si1, sj);
         if (!written_map[sj1 * SRC_MAX + si]) write_px(si, sj1);
         if (!written_map[sj1 * SRC_MAX + si1]) write_px(si1, sj1);
      end
      b = '0;
      b.act  = ACT_REQUEST;
      b.dcol = dc;
      b.drow = dr;
      push(b, 1'b0, '0);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_SRC_WIDTH:  reg_sw = 64'(val & 13'h1FF);
         CSR_SRC_HEIGHT: reg_sh = 64'(val & 13'h1FF);
         CSR_DST_WIDTH:  reg_dw = 64'(val);
         CSR_DST_HEIGHT: reg_dh = 64'(val);
      endcase
   endtask

   task automatic set_sizes(input logic [12:0] sw, input logic [12:0] sh,
                            input logic [12:0] dw, input logic [12:0] dh);
      drain();
      csr_write(CSR_SRC_WIDTH, sw);
      csr_write(CSR_SRC_HEIGHT, sh);
      csr_write(CSR_DST_WIDTH, dw);
      csr_write(CSR_DST_HEIGHT, dh);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      n_phases++;
   endtask

   task automatic random_phase(input int count);
      int start;
      longint unsigned dw, dh;
      logic [11:0] dc, dr;
      start = n_writes + n_reqs;
      dw = eff(reg_dw, DST_MAX);
      dh = eff(reg_dh, DST_MAX);
      while (n_writes + n_reqs - start < count) begin
         case ($urandom_range(0, 19))
            0, 1: write_px(64'($urandom_range(0, 255)), 64'($urandom_range(0, 255)));
            2, 3: request_px(12'($urandom), 12'($urandom));
            4: request_px(12'(dw - 1), 12'(dh - 1));
            5: request_px(12'(dw - 1), 12'($urandom_range(0, 32'(dh - 1))));
            6: request_px(12'($urandom_range(0, 32'(dw - 1))), 12'(dh - 1));
            default: begin
               dc = 12'($urandom_range(0, 32'(dw - 1)));
               dr = 12'($urandom_range(0, 32'(dh - 1)));
               request_px(dc, dr);
            end
         endcase
      end
   endtask

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(negedge clock) begin
      scaled_px_t w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_rsp++;
         if (pending_px.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            w = pending_px.pop_front();
            if (rsp_bus.red_out !== w.red) begin
               $error("red_out expected %0d actual %0d", w.red, rsp_bus.red_out);
               errors++;
            end
            if (rsp_bus.green_out !== w.green) begin
               $error("green_out expected %0d actual %0d", w.green, rsp_bus.green_out);
               errors++;
            end
            if (rsp_bus.blue_out !== w.blue) begin
               $error("blue_out expected %0d actual %0d", w.blue, rsp_bus.blue_out);
               errors++;
            end
            if (rsp_bus.alpha_out !== w.alpha) begin
               $error("alpha_out expected %0d actual %0d", w.alpha, rsp_bus.alpha_out);
               errors++;
            end
            if (rsp_bus.out_of_range !== w.oor) begin
               $error("out_of_range expected %0d actual %0d", w.oor,
                      rsp_bus.out_of_range);
               errors++;
            end
         end
      end
   end

   // watchdog
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_MAX) begin
         @(negedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("watchdog: no beat for %0d cycles", STALL_MAX);
      $display("rgba_bilinear_scaler_unit_tb NOT OK");
      $finish;
   end

   table_row_t directed [] = '{
      '{'{ACT_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0}, 1'b0, '0},
      '{'{ACT_WRITE, 8'd1, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0}, 1'b0, '0},
      '{'{ACT_WRITE, 8'd0, 8'd1, 8'h12, 8'h34, 8'h56, 8'h78, 12'd0, 12'd0}, 1'b0, '0},
      '{'{ACT_WRITE, 8'd1, 8'd1, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 12'd0, 12'd0}, 1'b0, '0},
      '{'{ACT_WRITE, 8'd255, 8'd255, 8'h00, 8'hFF, 8'h00, 8'hFF, 12'd0, 12'd0},
        1'b0, '0},
      '{'{ACT_WRITE, 8'd254, 8'd255, 8'h80, 8'h7F, 8'h01, 8'hFE, 12'd0, 12'd0},
        1'b0, '0},
      '{'{ACT_REQUEST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0},
        1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
      '{'{ACT_REQUEST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd255, 12'd255},
        1'b1, '{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0}},
      '{'{ACT_REQUEST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd254, 12'd255},
        1'b0, '0},
      '{'{ACT_REQUEST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd256, 12'd0},
        1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
      '{'{ACT_REQUEST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd256},
        1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
      '{'{ACT_REQUEST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095},
        1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
      '{'{ACT_REQUEST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd255, 12'd4095},
        1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}}
   };

   initial begin
      reset     <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_SRC_WIDTH;
      csr_wdata <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.action   <= ACT_WRITE;
      req_bus.src_col  <= '0;
      req_bus.src_row  <= '0;
      req_bus.red_in   <= '0;
      req_bus.green_in <= '0;
      req_bus.blue_in  <= '0;
      req_bus.alpha_in <= '0;
      req_bus.dst_col  <= '0;
      req_bus.dst_row  <= '0;
      reg_sw = 256; reg_sh = 256; reg_dw = 256; reg_dh = 256;
      calm = 1'b0;
      errors = 0; n_writes = 0; n_reqs = 0; n_oor = 0; n_rsp = 0; n_phases = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) push(directed[k].beat, directed[k].typed, directed[k].want);
      random_phase(PHASE_LEN);

      set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
      random_phase(PHASE_LEN / 2);
      set_sizes(13'd256, 13'd256, 13'd4096, 13'd4096);
      calm = 1'b1;
      random_phase(PHASE_LEN);
      calm = 1'b0;
      set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
      random_phase(PHASE_LEN / 2);
      set_sizes(13'd511, 13'd511, 13'd8191, 13'd8191);
      random_phase(PHASE_LEN);
      set_sizes(13'd3, 13'd5, 13'd7, 13'd2);
      random_phase(PHASE_LEN);
      set_sizes(13'd200, 13'd17, 13'd13, 13'd4000);
      random_phase(PHASE_LEN);
      set_sizes(13'($urandom_range(1, 256)), 13'($urandom_range(1, 256)),
                13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      random_phase(PHASE_LEN);
      set_sizes(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)),
                13'($urandom_range(1, 300)), 13'($urandom_range(1, 300)));
      random_phase(PHASE_LEN);

      drain();
      $display("covered %0d pixel writes, %0d requests (%0d out of range), %0d responses",
               n_writes, n_reqs, n_oor, n_rsp);
      $display("over %0d size settings after the reset sizes", n_phases);
      if (errors == 0 && pending_px.size() == 0) begin
         $display("rgba_bilinear_scaler_unit_tb OK");
      end else begin
         $display("rgba_bilinear_scaler_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
